@@ src/nco_pkg.sv @@
// Package for the numerically controlled oscillator: item kind codes,
// register indexes, field widths and the quarter-wave sine table function.
// Depends on nothing; used by the top level and its checker.
package nco_pkg;

   localparam int KIND_BITS  = 2;
   localparam int STEP_BITS  = 32;
   localparam int CSR_BITS   = 32;
   localparam int INDEX_BITS = 1;

   localparam real TWO_PI = 6.28318530717959;
   localparam real ONE    = 1.0;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_STEP_EMIT = 2'd0,
      KIND_STEP      = 2'd1,
      KIND_CLEAR     = 2'd2,
      KIND_LOAD      = 2'd3
   } kind_type;

   typedef enum logic [INDEX_BITS-1:0] {
      CSR_CENTER_STEP = 1'b0,
      CSR_START_PHASE = 1'b1
   } csr_index_type;

   // Entry k of a quarter wave with 2^quarter_bits steps, amplitude
   // 2^(out_bits-1) - 1, rounded to nearest. Evaluated at elaboration only.
   function automatic int quarter_entry(input int k, input int quarter_bits,
                                        input int out_bits);
      real amp;
      real angle;
      real value;
      int  result;
      amp    = (2.0 ** (out_bits - 1)) - ONE;
      angle  = TWO_PI * k * (2.0 ** (-(quarter_bits + 2)));
      value  = amp * $sin(angle);
      result = int'(value);
      if (result < 0) begin
         result = 0;
      end
      if (real'(result) > amp) begin
         result = int'(amp);
      end
      return result;
   endfunction

endpackage

@@ src/numerically_controlled_oscillator_top.sv @@
// Numerically controlled oscillator: phase accumulator, lookup stage and
// output register. Depends on nco_pkg for kind codes, register indexes and
// the quarter-wave table function.
//
// Usage: each word on the req channel carries a kind and a frequency offset.
// A step-and-emit word adds center_step + freq_step to the phase and yields
// one rsp word with cosine and sine of the new phase; a step-only word adds
// without a result; a clear word zeroes the phase; a load word sets it to
// start_phase. The csr port writes center_step (index 0) and start_phase
// (index 1); the user must write them only while the block is idle, which
// the block does not enforce. The phase is updated in the cycle a word is
// accepted. One word can be accepted every cycle while req_stall is low,
// set by the single adder in the phase loop. A synchronous reset clears the
// phase, both registers and all pending results. When the receiver stalls,
// the output register holds its word and one more result waits in the
// lookup stage; req_stall rises only when both are full.
module numerically_controlled_oscillator_top #(
   parameter int PHASE_BITS      = 32,
   parameter int OUT_BITS        = 16,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [nco_pkg::INDEX_BITS-1:0]         csr_index,
   input  logic [nco_pkg::CSR_BITS-1:0]           csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [nco_pkg::KIND_BITS-1:0]          req_kind,
   input  logic signed [nco_pkg::STEP_BITS-1:0]   req_freq_step,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [OUT_BITS-1:0]             rsp_cos_value,
   output logic signed [OUT_BITS-1:0]             rsp_sin_value
);

   localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
   localparam int QUARTER_LEN  = 1 << QUARTER_BITS;
   localparam int STEP_BITS    = nco_pkg::STEP_BITS;

   logic [OUT_BITS-2:0] quarter_tab [QUARTER_LEN+1];

   for (genvar k = 0; k <= QUARTER_LEN; k++) begin : g_tab
      assign quarter_tab[k] =
         (OUT_BITS-1)'(nco_pkg::quarter_entry(k, QUARTER_BITS, OUT_BITS));
   end

   logic signed [STEP_BITS-1:0]     center_step_ff;
   logic [STEP_BITS-1:0]            start_phase_ff;
   logic [PHASE_BITS-1:0]           phase_acc_ff, phase_acc_in;
   logic                            stage_valid_ff, stage_valid_in;
   logic [TABLE_ADDR_BITS-1:0]      stage_addr_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_BITS-1:0]      rsp_cos_ff, rsp_sin_ff;
   logic signed [OUT_BITS-1:0]      cos_in, sin_in;

   logic                            req_accept;
   logic                            rsp_load;
   logic                            stage_load;
   nco_pkg::kind_type               kind;
   logic [STEP_BITS-1:0]            step_sum;
   logic [PHASE_BITS+STEP_BITS-1:0] step_wide, start_wide;
   logic [PHASE_BITS-1:0]           step_units, start_units;

   assign rsp_load   = !rsp_valid_ff || !rsp_stall;
   assign stage_load = !stage_valid_ff || rsp_load;
   assign req_stall  = !stage_load;
   assign req_accept = req_valid && stage_load;
   assign kind       = nco_pkg::kind_type'(req_kind);

   // Steps and start phase are in units of 2^-32 of a full turn; align them to the
   // accumulator width, flooring when the accumulator is narrower.
   assign step_sum    = STEP_BITS'(center_step_ff + req_freq_step);
   assign step_wide   = {step_sum, {PHASE_BITS{1'b0}}};
   assign start_wide  = {start_phase_ff, {PHASE_BITS{1'b0}}};
   assign step_units  = step_wide[PHASE_BITS+STEP_BITS-1 -: PHASE_BITS];
   assign start_units = start_wide[PHASE_BITS+STEP_BITS-1 -: PHASE_BITS];

   always_comb begin
      phase_acc_in   = phase_acc_ff;
      stage_valid_in = stage_valid_ff && !rsp_load;
      if (req_accept) begin
         stage_valid_in = (kind == nco_pkg::KIND_STEP_EMIT);
         unique case (kind)
            nco_pkg::KIND_STEP_EMIT,
            nco_pkg::KIND_STEP: begin
               phase_acc_in = phase_acc_ff + step_units;
            end
            nco_pkg::KIND_CLEAR: begin
               phase_acc_in = '0;
            end
            nco_pkg::KIND_LOAD: begin
               phase_acc_in = start_units;
            end
            default: begin
               phase_acc_in = phase_acc_ff;
            end
         endcase
      end
   end

   logic [1:0]              sin_quad, cos_quad;
   logic [QUARTER_BITS-1:0] quad_idx;
   logic [QUARTER_BITS:0]   sin_entry, cos_entry;
   logic [OUT_BITS-2:0]     sin_mag, cos_mag;

   assign sin_quad = stage_addr_ff[TABLE_ADDR_BITS-1 -: 2];
   assign cos_quad = sin_quad + 2'd1;
   assign quad_idx = stage_addr_ff[QUARTER_BITS-1:0];

   assign sin_entry = sin_quad[0] ? (QUARTER_BITS+1)'(QUARTER_LEN) - {1'b0, quad_idx}
                                  : {1'b0, quad_idx};
   assign cos_entry = cos_quad[0] ? (QUARTER_BITS+1)'(QUARTER_LEN) - {1'b0, quad_idx}
                                  : {1'b0, quad_idx};
   assign sin_mag   = quarter_tab[sin_entry];
   assign cos_mag   = quarter_tab[cos_entry];
   assign sin_in    = sin_quad[1] ? -signed'({1'b0, sin_mag}) : signed'({1'b0, sin_mag});
   assign cos_in    = cos_quad[1] ? -signed'({1'b0, cos_mag}) : signed'({1'b0, cos_mag});

   assign rsp_valid_in = rsp_load ? stage_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_step_ff <= '0;
         start_phase_ff <= '0;
         phase_acc_ff   <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (nco_pkg::csr_index_type'(csr_index))
               nco_pkg::CSR_CENTER_STEP: begin
                  center_step_ff <= csr_write_data;
               end
               nco_pkg::CSR_START_PHASE: begin
                  start_phase_ff <= csr_write_data;
               end
               default: begin
                  center_step_ff <= center_step_ff;
               end
            endcase
         end
         phase_acc_ff   <= phase_acc_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_addr_ff <= phase_acc_in[PHASE_BITS-1 -: TABLE_ADDR_BITS];
      end
      if (rsp_load && stage_valid_ff) begin
         rsp_cos_ff <= cos_in;
         rsp_sin_ff <= sin_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cos_value = rsp_cos_ff;
   assign rsp_sin_value = rsp_sin_ff;

endmodule

@@ src/nco_checker.sv @@
// Port-level checker for the numerically controlled oscillator, bound to
// the top level. Depends on nco_pkg for the kind codes.
module nco_checker #(
   parameter int OUT_BITS = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [nco_pkg::KIND_BITS-1:0]     req_kind,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [OUT_BITS-1:0]        rsp_cos_value,
   input logic signed [OUT_BITS-1:0]        rsp_sin_value
);

   localparam logic [OUT_BITS-1:0] MOST_NEGATIVE = {1'b1, {(OUT_BITS-1){1'b0}}};

   // A stalled result word holds its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cos_value)
                                 && $stable(rsp_sin_value))
      else $error("stalled result word changed");

   // A new result traces back to an accepted step-and-emit word.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall
                                 && req_kind == nco_pkg::KIND_STEP_EMIT, 2))
      else $error("result word without a step-and-emit word");

   // The input side is held off only while a result word is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty output register");

   // Table values stay within the symmetric amplitude.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cos_value != MOST_NEGATIVE && rsp_sin_value != MOST_NEGATIVE)
      else $error("result value outside the amplitude range");

endmodule

bind numerically_controlled_oscillator_top nco_checker #(
   .OUT_BITS(OUT_BITS)
) u_nco_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_kind      (req_kind),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_cos_value (rsp_cos_value),
   .rsp_sin_value (rsp_sin_value)
);

@@ test/tb_numerically_controlled_oscillator_top.sv @@
// Self-checking bench for numerically_controlled_oscillator_top: a queued word
// driver, a random receiver stall and a bit-exact phase and sine-table predictor.
// Depends on nco_pkg for the kind codes and register indexes.
module tb_numerically_controlled_oscillator_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_BITS      = 32;
   localparam int OUT_BITS        = 16;
   localparam int TABLE_ADDR_BITS = 10;
   localparam int QUARTER_BITS    = TABLE_ADDR_BITS - 2;
   localparam int QUARTER_LEN     = 1 << QUARTER_BITS;
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
   localparam logic [63:0] AMPLITUDE   = (64'd1 << (OUT_BITS - 1)) - 64'd1;
   localparam int IDLE_LIMIT      = 2000;
   localparam int TAIL_CYCLES     = 8;
   localparam int PHASE_ITEMS     = 100;

   typedef struct {
      nco_pkg::kind_type             kind;
      logic [nco_pkg::STEP_BITS-1:0] freq_step;
   } osc_word_type;

   typedef struct {
      logic signed [OUT_BITS-1:0] cos_value;
      logic signed [OUT_BITS-1:0] sin_value;
   } osc_sample_type;

   logic                                 clock            = 1'b0;
   logic                                 reset            = 1'b1;
   logic                                 csr_write_enable = 1'b0;
   logic [nco_pkg::INDEX_BITS-1:0]       csr_index        = '0;
   logic [nco_pkg::CSR_BITS-1:0]         csr_write_data   = '0;
   logic                                 req_valid        = 1'b0;
   logic                                 req_stall;
   logic [nco_pkg::KIND_BITS-1:0]        req_kind         = '0;
   logic signed [nco_pkg::STEP_BITS-1:0] req_freq_step    = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall        = 1'b0;
   logic signed [OUT_BITS-1:0]           rsp_cos_value;
   logic signed [OUT_BITS-1:0]           rsp_sin_value;

   osc_word_type   pending_words[$];
   osc_sample_type expected_samples[$];

   int          sine_quarter[0:QUARTER_LEN];
   logic [PHASE_BITS-1:0] model_phase  = '0;
   logic [31:0]           model_center = '0;
   logic [31:0]           model_start  = '0;

   logic        req_word_taken = 1'b0;
   bit          calm           = 1'b0;
   int          send_gap       = 0;
   int          stall_left     = 0;
   int          idle_cycles    = 0;
   int          mismatches     = 0;
   osc_sample_type want;
   osc_sample_type predicted;

   numerically_controlled_oscillator_top #(
      .PHASE_BITS      (PHASE_BITS),
      .OUT_BITS        (OUT_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_freq_step    (req_freq_step),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cos_value    (rsp_cos_value),
      .rsp_sin_value    (rsp_sin_value)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Fixed-point helpers for the table: floor(a * b / 2^62) and a Taylor sine.
   function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   function automatic logic [63:0] q62_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] n;
      x2   = q62_product(x, x);
      term = x;
      pos  = x;
      neg  = 64'd0;
      n    = 64'd1;
      for (int i = 0; i < 40 && term != 64'd0; i++) begin
         term = q62_product(term, x2) / ((n + 64'd1) * (n + 64'd2));
         n = n + 64'd2;
         if (i % 2 == 1) begin
            pos = pos + term;
         end else begin
            neg = neg + term;
         end
      end
      return (pos > neg) ? pos - neg : 64'd0;
   endfunction

   task automatic build_sine_quarter();
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] x;
      logic [63:0] twice;
      logic [63:0] v;
      hi = HALF_PI_Q62 >> QUARTER_BITS;
      lo = HALF_PI_Q62 & ((64'd1 << QUARTER_BITS) - 64'd1);
      for (int k = 0; k <= QUARTER_LEN; k++) begin
         x     = hi * 64'(k) + ((lo * 64'(k)) >> QUARTER_BITS);
         twice = q62_product(q62_sine(x), 64'd2 * AMPLITUDE);
         v     = (twice + 64'd1) >> 1;
         if (v > AMPLITUDE) begin
            v = AMPLITUDE;
         end
         sine_quarter[k] = int'(v);
      end
   endtask

   function automatic logic signed [OUT_BITS-1:0] wave_lookup(
      input logic [TABLE_ADDR_BITS-1:0] addr);
      logic [1:0]                 quad;
      int                         idx;
      int                         v;
      logic signed [OUT_BITS-1:0] r;
      quad = addr[TABLE_ADDR_BITS-1 -: 2];
      idx  = int'(addr[QUARTER_BITS-1:0]);
      v    = quad[0] ? sine_quarter[QUARTER_LEN - idx] : sine_quarter[idx];
      r    = v[OUT_BITS-1:0];
      return quad[1] ? -r : r;
   endfunction

   // Applies one accepted word to the phase; returns 1 when it yields a sample.
   function automatic bit advance_oscillator(input osc_word_type w,
                                             output osc_sample_type s);
      logic [TABLE_ADDR_BITS-1:0] addr;
      logic [TABLE_ADDR_BITS-1:0] cos_addr;
      s = '{default: '0};
      case (w.kind)
         nco_pkg::KIND_CLEAR: begin
            model_phase = '0;
            return 1'b0;
         end
         nco_pkg::KIND_LOAD: begin
            model_phase = model_start;
            return 1'b0;
         end
         default: begin
            model_phase = model_phase + model_center + w.freq_step;
         end
      endcase
      if (w.kind == nco_pkg::KIND_STEP) begin
         return 1'b0;
      end
      addr        = model_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
      cos_addr    = addr + TABLE_ADDR_BITS'(QUARTER_LEN);
      s.sin_value = wave_lookup(addr);
      s.cos_value = wave_lookup(cos_addr);
      return 1'b1;
   endfunction

   function automatic logic [31:0] random_step();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               default: return 32'h0000_0000;
            endcase
         end
         default: return 32'($urandom_range(0, 1023)) << 22;
      endcase
   endfunction

   function automatic osc_word_type random_word();
      osc_word_type w;
      int           r;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         w.kind = nco_pkg::KIND_STEP_EMIT;
      end else if (r < 8) begin
         w.kind = nco_pkg::KIND_STEP;
      end else if (r == 8) begin
         w.kind = nco_pkg::KIND_CLEAR;
      end else begin
         w.kind = nco_pkg::KIND_LOAD;
      end
      w.freq_step = random_step();
      return w;
   endfunction

   task automatic queue_word(input nco_pkg::kind_type kind, input logic [31:0] freq_step);
      pending_words.push_back('{kind: kind, freq_step: freq_step});
   endtask

   task automatic write_csr(input nco_pkg::csr_index_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Holds the sender off until every word is taken and every sample is back.
   task automatic drain();
      while (pending_words.size() != 0 || req_valid || expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Word driver.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_word_taken) begin
            req_valid <= 1'b1;
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  = send_gap - 1;
         end else if (pending_words.size() != 0) begin
            req_valid     <= 1'b1;
            req_kind      <= pending_words[0].kind;
            req_freq_step <= pending_words[0].freq_step;
            void'(pending_words.pop_front());
            if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 18);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
      end
   end

   // Prediction, checking and watchdog at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         req_word_taken <= 1'b0;
         model_phase  = '0;
         model_center = '0;
         model_start  = '0;
      end else begin
         req_word_taken <= req_valid && !req_stall;
         if (csr_write_enable) begin
            if (csr_index == nco_pkg::CSR_CENTER_STEP) begin
               model_center = csr_write_data;
            end else begin
               model_start = csr_write_data;
            end
         end
         if (req_valid && !req_stall) begin
            if (advance_oscillator('{kind: nco_pkg::kind_type'(req_kind),
                                     freq_step: req_freq_step}, predicted)) begin
               expected_samples.push_back(predicted);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected word: cos %0d sin %0d", rsp_cos_value, rsp_sin_value);
               end
               mismatches++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_cos_value !== want.cos_value || rsp_sin_value !== want.sin_value) begin
                  if (mismatches < 10) begin
                     $display("mismatch: cos expected %0d got %0d, sin expected %0d got %0d",
                              want.cos_value, rsp_cos_value, want.sin_value, rsp_sin_value);
                  end
                  mismatches++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   initial begin
      logic [31:0] centers[5];
      logic [31:0] starts[5];
      build_sine_quarter();
      centers = '{32'h8000_0000, $urandom, 32'h0040_0000, 32'hFFFF_FFFF, 32'h0000_0000};
      starts  = '{32'h0000_0000, $urandom, 32'h4000_0000, $urandom, 32'hFFFF_FFFF};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Quarter turns, extreme offsets and sub-step truncation at reset settings.
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'h0000_0000);
      repeat (4) queue_word(nco_pkg::KIND_STEP_EMIT, 32'h4000_0000);
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'h7FFF_FFFF);
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'h8000_0000);
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'hFFFF_FFFF);
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'h0000_0001);
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'h003F_FFFF);
      queue_word(nco_pkg::KIND_STEP, 32'h1234_5678);
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'h0000_0000);
      queue_word(nco_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'h0000_0000);
      queue_word(nco_pkg::KIND_LOAD, 32'h5555_5555);
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'h0040_0000);
      drain();

      // The tuning sum overflows past the largest positive step.
      write_csr(nco_pkg::CSR_CENTER_STEP, 32'h7FFF_FFFF);
      write_csr(nco_pkg::CSR_START_PHASE, 32'hFFFF_FFFF);
      queue_word(nco_pkg::KIND_LOAD, 32'h0000_0000);
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'h7FFF_FFFF);
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'h8000_0000);
      queue_word(nco_pkg::KIND_STEP, 32'h7FFF_FFFF);
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'h0000_0000);
      queue_word(nco_pkg::KIND_CLEAR, 32'h0000_0000);
      queue_word(nco_pkg::KIND_STEP_EMIT, 32'h0000_0000);
      drain();

      for (int p = 0; p < 5; p++) begin
         write_csr(nco_pkg::CSR_CENTER_STEP, centers[p]);
         write_csr(nco_pkg::CSR_START_PHASE, starts[p]);
         if (p == 4) begin
            calm = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pending_words.push_back(random_word());
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/nco_pkg.sv
src/numerically_controlled_oscillator_top.sv
src/nco_checker.sv
test/tb_numerically_controlled_oscillator_top.sv
